>>> design/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg
// types and constants shared by the lru tag store modules
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int LINE_BYTES   = 64;
  localparam int SETS         = 64;
  localparam int WAYS         = 8;
  localparam int ADDRESS_BITS = 48;
  localparam int TIME_BITS    = 32;

  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SET_USED = $clog2(SETS);
  localparam int TAG_BITS = ADDRESS_BITS - OFF_BITS - SET_USED;
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int Q_DEPTH  = 2;

  typedef enum logic {
    OP_LOOKUP  = 1'b0,
    OP_INSTALL = 1'b1
  } op_t;

  typedef struct packed {
    logic        op;
    logic [47:0] address;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] way;
    logic       replaced;
  } resp_t;

  // decoded word handed from front to back
  typedef struct packed {
    op_t                  op;
    logic [SET_BITS-1:0]  set_idx;
    logic [TAG_BITS-1:0]  tag;
    logic [TIME_BITS-1:0] now;
  } cmd_t;

endpackage

>>> design/set_assoc_lru_tag_store_core.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_store_core
// tag store of a set-associative cache with timestamp lru replacement
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy is high only while
// the two-entry queue between front and back is full. The front splits the
// address into set and tag. The back reads the whole set into registers, and
// in the next state compares tags, finds the first empty way or the oldest
// timestamp, and writes back tag and timestamp on an install, and only the
// timestamp on a lookup hit. The back end takes no new word until it has
// written back the last one. A word taken while the back end is idle goes
// through the queue, the read state and the write state, then done is set.
// The result appears on result for exactly one cycle with done high;
// the receiver cannot stall and must take it then. Reset clears the queue
// and the sequencer; after reset the back end clears the valid bits of every
// set, one set per cycle, and meanwhile up to two words wait in the queue.
// Tags and timestamps are not cleared, since a way is only looked at once
// its valid bit is set.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_store_core import salru_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  req_t  request,
  output logic  done,
  output resp_t result
);

  logic full, empty, pop;
  cmd_t head;

  salru_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(start),
    .in_word (request),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .head    (head)
  );

  salru_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_strobe(done),
    .out_word  (result)
  );

  assign busy = full;

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_done_after_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> ##1 done) else $error("missing result after pop");
  a_no_double_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("results back to back");
  a_hit_lookup: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.hit && result.replaced)) else $error("hit and replaced");

endmodule

>>> design/salru_front.sv
// ----------------------------------------------------------------------------
// salru_front
// accepts words, splits the address into set and tag, queues them
// ----------------------------------------------------------------------------
module salru_front import salru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  req_t in_word,
  output logic full,
  output logic empty,
  input  logic pop,
  output cmd_t head
);

  cmd_t                  q [Q_DEPTH];
  logic [$clog2(Q_DEPTH):0] count;
  logic [$clog2(Q_DEPTH)-1:0] wr_ptr, rd_ptr;
  cmd_t cmd;
  logic push;

  always_comb begin
    cmd.op      = op_t'(in_word.op);
    if (SETS > 1) begin
      cmd.set_idx = SET_BITS'(in_word.address[ADDRESS_BITS-1:0] >> OFF_BITS);
    end else begin
      cmd.set_idx = '0;
    end
    cmd.tag     = TAG_BITS'(in_word.address[ADDRESS_BITS-1:0] >> (OFF_BITS + SET_USED));
    cmd.now     = in_word.now[TIME_BITS-1:0];
  end

  assign full  = (count == ($clog2(Q_DEPTH)+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign push  = in_valid && !full;
  assign head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd;
    end
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

endmodule

>>> design/salru_back.sv
// ----------------------------------------------------------------------------
// salru_back
// reads one set, picks hit / empty / victim way, writes the set back on an install or a hit
// ----------------------------------------------------------------------------
module salru_back import salru_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  empty,
  input  cmd_t  head,
  output logic  pop,
  output logic  out_strobe,
  output resp_t out_word
);

  typedef enum logic { S_READ, S_WRITE } state_t;

  state_t state;
  cmd_t   cur;

  // one row per set, all ways side by side
  logic [WAYS*TAG_BITS-1:0]  tag_mem  [SETS];
  logic [WAYS*TIME_BITS-1:0] time_mem [SETS];
  logic [WAYS*TAG_BITS-1:0]  tag_row;
  logic [WAYS*TIME_BITS-1:0] time_row;
  logic [WAYS-1:0]           valid [SETS];
  logic [WAYS-1:0]           vrow;

  // valid rows are cleared one set per cycle after reset
  logic                clearing;
  logic [SET_BITS-1:0] clr_idx;

  logic                match, free;
  logic [WAY_BITS-1:0] hit_way, free_way, vict_way, sel_way;
  logic [TIME_BITS-1:0] vict_time, t;

  always_comb begin
    match     = 1'b0;
    free      = 1'b0;
    hit_way   = '0;
    free_way  = '0;
    vict_way  = '0;
    vict_time = time_row[TIME_BITS-1:0];
    for (int w = WAYS-1; w >= 0; w--) begin
      if (vrow[w] && tag_row[w*TAG_BITS +: TAG_BITS] == cur.tag) begin
        match   = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!vrow[w]) begin
        free     = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      t = time_row[w*TIME_BITS +: TIME_BITS];
      if (t < vict_time) begin
        vict_time = t;
        vict_way  = WAY_BITS'(w);
      end
    end
    if (cur.op == OP_LOOKUP) sel_way = hit_way;
    else if (free)           sel_way = free_way;
    else                     sel_way = vict_way;
  end

  assign pop = (state == S_READ) && !empty && !clearing;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= head;
      tag_row  <= tag_mem[head.set_idx];
      time_row <= time_mem[head.set_idx];
    end
    if (state == S_WRITE) begin
      if (cur.op == OP_INSTALL) begin
        tag_mem[cur.set_idx][sel_way*TAG_BITS +: TAG_BITS] <= cur.tag;
      end
      if (cur.op == OP_INSTALL || match) begin
        time_mem[cur.set_idx][sel_way*TIME_BITS +: TIME_BITS] <= cur.now;
      end
    end
    out_word.hit      <= (cur.op == OP_LOOKUP) && match;
    // a lookup miss leaves sel_way at zero
    out_word.way      <= 3'(32'(sel_way) & 32'd7);
    out_word.replaced <= (cur.op == OP_INSTALL) && !free;
    if (rst) begin
      state      <= S_READ;
      out_strobe <= 1'b0;
      clearing   <= 1'b1;
      clr_idx    <= '0;
    end else begin
      if (clearing) begin
        valid[clr_idx] <= '0;
        clr_idx        <= clr_idx + 1'b1;
        if (clr_idx == SET_BITS'(SETS-1)) clearing <= 1'b0;
      end
      unique case (state)
        S_READ: begin
          out_strobe <= 1'b0;
          if (pop) begin
            vrow  <= valid[head.set_idx];
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          out_strobe <= 1'b1;
          if (cur.op == OP_INSTALL) valid[cur.set_idx][sel_way] <= 1'b1;
          state <= S_READ;
        end
        default: state <= S_READ;
      endcase
    end
  end

endmodule
